FILE: src/jmse_pkg.sv
// shared types and constants for the jtag master shift engine
package jmse_pkg;

    localparam int CHUNK_BITS_DEF = 32;
    localparam int DIV_W          = 16;
    localparam int COUNT_W        = 6;
    localparam int DATA_W         = 32;
    localparam int KIND_W         = 2;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_TMS       = 2'd0,
        KIND_SHIFT_CAP = 2'd1,
        KIND_SHIFT     = 2'd2,
        KIND_CONST     = 2'd3
    } t_kind;

    typedef struct packed {
        logic              tck;
        logic              tms;
        logic              tdi;
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] captured;
        logic              rejected;
    } t_result;

endpackage

FILE: src/jtag_master_shift_engine.sv
// JTAG master shift engine: while input ready is high, takes one item per clock (a time tick or
// a command start) and returns one result item per input item through an output register.
// Input ready is high whenever that register is empty or its item is taken in the same
// cycle, so with a ready consumer the block sustains one item every cycle. A TCK half
// period spans clk_divider+1 tick items; a command of N bits completes after
// 2*N*(clk_divider+1) tick items, with TDO sampled on the tick where TCK falls.
module jtag_master_shift_engine
    import jmse_pkg::*;
#(
    parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DIV_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [COUNT_W-1:0] i_bit_count,
    input  logic [DATA_W-1:0]  i_tms_bits,
    input  logic [DATA_W-1:0]  i_tdi_bits,
    input  logic               i_tms_exit,
    input  logic               i_tms_level,
    input  logic               i_tdi_level,
    input  logic               i_tdo_pin,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_tck_out,
    output logic               o_tms_out,
    output logic               o_tdi_out,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic [DATA_W-1:0]  o_captured,
    output logic               o_rejected
);

    logic    accept;
    logic    free;
    t_result core_res;
    t_result out_res;

    assign o_in_ready = free;
    assign accept     = i_in_valid && free;

    jmse_core #(
        .CHUNK_BITS (CHUNK_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_kind      (i_kind),
        .i_bit_count (i_bit_count),
        .i_tms_bits  (i_tms_bits),
        .i_tdi_bits  (i_tdi_bits),
        .i_tms_exit  (i_tms_exit),
        .i_tms_level (i_tms_level),
        .i_tdi_level (i_tdi_level),
        .i_tdo_pin   (i_tdo_pin),
        .o_result    (core_res)
    );

    jmse_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (core_res),
        .i_ready  (i_out_ready),
        .o_free   (free),
        .o_valid  (o_out_valid),
        .o_result (out_res)
    );

    assign o_tck_out  = out_res.tck;
    assign o_tms_out  = out_res.tms;
    assign o_tdi_out  = out_res.tdi;
    assign o_busy_res = out_res.busy;
    assign o_done_res = out_res.done;
    assign o_captured = out_res.captured;
    assign o_rejected = out_res.rejected;

endmodule

FILE: src/jmse_core.sv
// command state and per-item tap shifting logic
module jmse_core
    import jmse_pkg::*;
#(
    parameter int CHUNK_BITS = CHUNK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [DIV_W-1:0]   i_cfg_data,
    input  logic               i_accept,
    input  logic               i_op,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [COUNT_W-1:0] i_bit_count,
    input  logic [DATA_W-1:0]  i_tms_bits,
    input  logic [DATA_W-1:0]  i_tdi_bits,
    input  logic               i_tms_exit,
    input  logic               i_tms_level,
    input  logic               i_tdi_level,
    input  logic               i_tdo_pin,
    output t_result            o_result
);

    localparam int CW  = CHUNK_BITS;
    localparam int BIW = $clog2(CW + 1);
    localparam int IW  = $clog2(CW);
    localparam int SW  = (BIW > COUNT_W) ? BIW + 1 : COUNT_W + 1;

    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_tick,     n_tick;
    logic             r_high,     n_high;
    logic [BIW-1:0]   r_bit_idx,  n_bit_idx;
    logic [BIW-1:0]   r_cycles,   n_cycles;
    logic [CW-1:0]    r_tms_sh,   n_tms_sh;
    logic [CW-1:0]    r_tdi_sh,   n_tdi_sh;
    logic [CW-1:0]    r_cap,      n_cap;
    t_kind            r_kind,     n_kind;
    logic             r_last_tms, n_last_tms;
    logic             r_running,  n_running;
    logic             r_tms_pin,  n_tms_pin;
    logic             r_tdi_pin,  n_tdi_pin;

    logic             do_drive;
    logic             on_last;
    logic             done;
    logic             rejected;
    logic [BIW-1:0]   count_sat;
    logic [DATA_W-1:0] cap_out;

    always_comb begin
        n_tick     = r_tick;
        n_high     = r_high;
        n_bit_idx  = r_bit_idx;
        n_cycles   = r_cycles;
        n_tms_sh   = r_tms_sh;
        n_tdi_sh   = r_tdi_sh;
        n_cap      = r_cap;
        n_kind     = r_kind;
        n_last_tms = r_last_tms;
        n_running  = r_running;
        n_tms_pin  = r_tms_pin;
        n_tdi_pin  = r_tdi_pin;
        do_drive   = 1'b0;
        on_last    = 1'b0;
        done       = 1'b0;
        rejected   = 1'b0;
        cap_out    = '0;
        count_sat  = (SW'(i_bit_count) > SW'(CW)) ? BIW'(CW) : BIW'(i_bit_count);

        if (i_accept) begin
            if (t_op'(i_op) == OP_START) begin
                if (r_running) begin
                    rejected = 1'b1;
                end else begin
                    n_kind     = t_kind'(i_kind);
                    n_cycles   = count_sat;
                    n_tms_sh   = CW'(i_tms_bits);
                    n_tdi_sh   = CW'(i_tdi_bits);
                    n_last_tms = i_tms_exit;
                    n_cap      = '0;
                    n_bit_idx  = '0;
                    n_tick     = '0;
                    n_high     = 1'b0;
                    case (t_kind'(i_kind))
                        KIND_TMS: begin
                            n_tdi_pin = 1'b1;
                        end
                        KIND_SHIFT_CAP: begin
                            n_tms_pin = 1'b0;
                            n_tdi_pin = 1'b0;
                        end
                        KIND_SHIFT: begin
                            n_tms_pin = 1'b0;
                        end
                        default: begin
                            n_tms_pin = i_tms_level;
                            n_tdi_pin = i_tdi_level;
                        end
                    endcase
                    if (count_sat == '0) begin
                        done = 1'b1;
                    end else begin
                        n_running = 1'b1;
                        do_drive  = 1'b1;
                    end
                end
            end else if (r_running) begin
                if (r_tick < r_div) begin
                    n_tick = r_tick + 1'b1;
                end else begin
                    n_tick = '0;
                    if (!r_high) begin
                        n_high = 1'b1;
                    end else begin
                        // sample tdo as tck falls
                        if (r_kind == KIND_SHIFT_CAP ||
                            (r_kind == KIND_CONST && r_bit_idx == '0)) begin
                            n_cap[r_bit_idx[IW-1:0]] = i_tdo_pin;
                        end
                        n_high    = 1'b0;
                        n_bit_idx = r_bit_idx + 1'b1;
                        n_tms_sh  = r_tms_sh >> 1;
                        n_tdi_sh  = r_tdi_sh >> 1;
                        if (n_bit_idx >= r_cycles) begin
                            n_running = 1'b0;
                            done      = 1'b1;
                            cap_out   = DATA_W'(n_cap);
                        end else begin
                            do_drive = 1'b1;
                        end
                    end
                end
            end
        end

        // levels for the bit now starting
        if (do_drive) begin
            on_last = ((BIW + 1)'(n_bit_idx) + 1'b1) >= (BIW + 1)'(n_cycles);
            case (n_kind)
                KIND_TMS: begin
                    n_tms_pin = n_tms_sh[0];
                    n_tdi_pin = 1'b1;
                end
                KIND_SHIFT_CAP, KIND_SHIFT: begin
                    n_tms_pin = on_last && n_last_tms;
                    n_tdi_pin = n_tdi_sh[0];
                end
                default: begin
                end
            endcase
        end

        o_result.tck      = n_high;
        o_result.tms      = n_tms_pin;
        o_result.tdi      = n_tdi_pin;
        o_result.busy     = n_running;
        o_result.done     = done;
        o_result.captured = cap_out;
        o_result.rejected = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div      <= '0;
            r_tick     <= '0;
            r_high     <= 1'b0;
            r_bit_idx  <= '0;
            r_cycles   <= '0;
            r_tms_sh   <= '0;
            r_tdi_sh   <= '0;
            r_cap      <= '0;
            r_kind     <= KIND_TMS;
            r_last_tms <= 1'b0;
            r_running  <= 1'b0;
            r_tms_pin  <= 1'b0;
            r_tdi_pin  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_div <= i_cfg_data;
            end
            r_tick     <= n_tick;
            r_high     <= n_high;
            r_bit_idx  <= n_bit_idx;
            r_cycles   <= n_cycles;
            r_tms_sh   <= n_tms_sh;
            r_tdi_sh   <= n_tdi_sh;
            r_cap      <= n_cap;
            r_kind     <= n_kind;
            r_last_tms <= n_last_tms;
            r_running  <= n_running;
            r_tms_pin  <= n_tms_pin;
            r_tdi_pin  <= n_tdi_pin;
        end
    end

    a_high_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high |-> r_running)
        else $error("tck high while idle");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_bit_idx < r_cycles))
        else $error("bit index past command length");

    a_reject_keeps_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_op && r_running) |=> (r_running && $stable(r_cycles)
            && $stable(r_bit_idx) && $stable(r_tick)))
        else $error("rejected start disturbed running command");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_tick == '0 && !r_high))
        else $error("phase timer not cleared while idle");

endmodule

FILE: src/jmse_out_reg.sv
// result register between the shift logic and the output channel
module jmse_out_reg
    import jmse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // can take a new item when empty or when the held one leaves now
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
